// ===== src/rotation_matrix_to_quaternion_defines.svh =====
// ---------------------------------------------------------------------------
// Rotation matrix to quaternion: assertion macros
// Shared concurrent assertion forms for the checker.
// ---------------------------------------------------------------------------
`ifndef ROTATION_MATRIX_TO_QUATERNION_DEFINES_SVH
`define ROTATION_MATRIX_TO_QUATERNION_DEFINES_SVH

// same-cycle implication, off during reset
`define RMQ_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rmq: assertion failed");

// next-cycle implication, off during reset
`define RMQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rmq: assertion failed");

// same-cycle implication, also checked during reset
`define RMQ_ASSERT_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("rmq: assertion failed");

`endif

// ===== src/rmq_pkg.sv =====
// ---------------------------------------------------------------------------
// Rotation matrix to quaternion: package
// Field widths, output limits and default fraction width.
// ---------------------------------------------------------------------------
`default_nettype none

package rmq_pkg;

  localparam int IN_W          = 18;
  localparam int OUT_W         = 18;
  localparam int QUAT_N        = 4;
  localparam int FRAC_BITS_DEF = 16;

  localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

endpackage

`default_nettype wire

// ===== src/rmq_mat_if.sv =====
// ---------------------------------------------------------------------------
// Matrix channel
// Valid/ready channel carrying one 3x3 matrix per transfer.
// ---------------------------------------------------------------------------
`default_nettype none

interface rmq_mat_if;
  logic                             valid;
  logic                             ready;
  logic signed [rmq_pkg::IN_W-1:0] m00;
  logic signed [rmq_pkg::IN_W-1:0] m01;
  logic signed [rmq_pkg::IN_W-1:0] m02;
  logic signed [rmq_pkg::IN_W-1:0] m10;
  logic signed [rmq_pkg::IN_W-1:0] m11;
  logic signed [rmq_pkg::IN_W-1:0] m12;
  logic signed [rmq_pkg::IN_W-1:0] m20;
  logic signed [rmq_pkg::IN_W-1:0] m21;
  logic signed [rmq_pkg::IN_W-1:0] m22;

  modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  input ready);
  modport sink (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                output ready);
endinterface

`default_nettype wire

// ===== src/rmq_quat_if.sv =====
// ---------------------------------------------------------------------------
// Quaternion channel
// Valid/ready channel carrying one unit quaternion and flags per transfer.
// ---------------------------------------------------------------------------
`default_nettype none

interface rmq_quat_if;
  logic                              valid;
  logic                              ready;
  logic signed [rmq_pkg::OUT_W-1:0] quat_w;
  logic signed [rmq_pkg::OUT_W-1:0] quat_x;
  logic signed [rmq_pkg::OUT_W-1:0] quat_y;
  logic signed [rmq_pkg::OUT_W-1:0] quat_z;
  logic                              x_branch;
  logic                              degenerate;

  modport source (output valid, quat_w, quat_x, quat_y, quat_z, x_branch, degenerate,
                  input ready);
  modport sink (input valid, quat_w, quat_x, quat_y, quat_z, x_branch, degenerate,
                output ready);
endinterface

`default_nettype wire

// ===== src/rmq_sqrt.sv =====
// ---------------------------------------------------------------------------
// Pipelined integer square root
// Floor root, one result bit per register stage, sideband carried along.
// ---------------------------------------------------------------------------
`default_nettype none

module rmq_sqrt #(
  parameter int RIW = 36,
  parameter int SW  = 1
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire logic               in_valid,
  input  wire logic [RIW-1:0]     radicand,
  input  wire logic [SW-1:0]      side_in,
  output logic                    out_valid,
  output logic [RIW/2-1:0]        root,
  output logic [SW-1:0]           side_out
);

  localparam int ROW = RIW / 2;
  localparam int AW  = RIW + 1;

  logic [ROW:0]   vld;
  logic [AW-1:0]  rem_s  [ROW+1];
  logic [ROW-1:0] root_s [ROW+1];
  logic [SW-1:0]  side_s [ROW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[ROW-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_s[0]  <= AW'(radicand);
      root_s[0] <= '0;
      side_s[0] <= side_in;
      for (int k = 0; k < ROW; k++) begin
        side_s[k+1] <= side_s[k];
        if (rem_s[k] >= ((AW'(root_s[k]) << (ROW - k)) | (AW'(1) << (2 * (ROW - 1 - k)))))
        begin
          rem_s[k+1]  <= rem_s[k] -
                         ((AW'(root_s[k]) << (ROW - k)) | (AW'(1) << (2 * (ROW - 1 - k))));
          root_s[k+1] <= root_s[k] | (ROW'(1) << (ROW - 1 - k));
        end else begin
          rem_s[k+1]  <= rem_s[k];
          root_s[k+1] <= root_s[k];
        end
      end
    end
  end

  assign out_valid = vld[ROW];
  assign root      = root_s[ROW];
  assign side_out  = side_s[ROW];

endmodule

`default_nettype wire

// ===== src/rmq_div.sv =====
// ---------------------------------------------------------------------------
// Pipelined restoring divider
// Several dividends over one shared divisor, one quotient bit per stage,
// with an overflow flag for quotients that do not fit.
// ---------------------------------------------------------------------------
`default_nettype none

module rmq_div #(
  parameter int NW = 35,
  parameter int DW = 19,
  parameter int QW = 17,
  parameter int NL = 3,
  parameter int SW = 1
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire logic [NW-1:0] num [NL],
  input  wire logic [DW-1:0] den,
  input  wire logic [SW-1:0] side_in,
  output logic               out_valid,
  output logic [QW-1:0]      quo [NL],
  output logic               ovf [NL],
  output logic [SW-1:0]      side_out
);

  localparam int AW = ((NW > DW + QW) ? NW : DW + QW) + 1;

  logic [QW:0]    vld;
  logic [AW-1:0]  rem_s  [QW+1][NL];
  logic [QW-1:0]  quo_s  [QW+1][NL];
  logic           ovf_s  [QW+1][NL];
  logic [DW-1:0]  den_s  [QW+1];
  logic [SW-1:0]  side_s [QW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[QW-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_s[0]  <= den;
      side_s[0] <= side_in;
      for (int l = 0; l < NL; l++) begin
        rem_s[0][l] <= AW'(num[l]);
        quo_s[0][l] <= '0;
        ovf_s[0][l] <= AW'(num[l]) >= (AW'(den) << QW);
      end
      for (int k = 0; k < QW; k++) begin
        den_s[k+1]  <= den_s[k];
        side_s[k+1] <= side_s[k];
        for (int l = 0; l < NL; l++) begin
          ovf_s[k+1][l] <= ovf_s[k][l];
          if (rem_s[k][l] >= (AW'(den_s[k]) << (QW - 1 - k))) begin
            rem_s[k+1][l] <= rem_s[k][l] - (AW'(den_s[k]) << (QW - 1 - k));
            quo_s[k+1][l] <= quo_s[k][l] | (QW'(1) << (QW - 1 - k));
          end else begin
            rem_s[k+1][l] <= rem_s[k][l];
            quo_s[k+1][l] <= quo_s[k][l];
          end
        end
      end
    end
  end

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      quo[l] = quo_s[QW][l];
      ovf[l] = ovf_s[QW][l];
    end
  end

  assign out_valid = vld[QW];
  assign side_out  = side_s[QW];

endmodule

`default_nettype wire

// ===== src/rmq_sumsq.sv =====
// ---------------------------------------------------------------------------
// Sum of squares
// Squares four magnitudes in one stage and adds them in the next.
// ---------------------------------------------------------------------------
`default_nettype none

module rmq_sumsq #(
  parameter int MW = 17,
  parameter int SW = 1
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire logic [MW-1:0] mag [rmq_pkg::QUAT_N],
  input  wire logic [SW-1:0] side_in,
  output logic               out_valid,
  output logic [2*MW+1:0]    sum,
  output logic [SW-1:0]      side_out
);

  localparam int NQ = rmq_pkg::QUAT_N;

  logic [1:0]      vld;
  logic [2*MW-1:0] sq [NQ];
  logic [SW-1:0]   side_r;
  logic [2*MW+1:0] sum_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < NQ; l++) begin
        sq[l] <= mag[l] * mag[l];
      end
      side_r   <= side_in;
      sum_r    <= (2*MW+2)'(sq[0]) + (2*MW+2)'(sq[1]) + (2*MW+2)'(sq[2]) + (2*MW+2)'(sq[3]);
      side_out <= side_r;
    end
  end

  assign out_valid = vld[1];
  assign sum       = sum_r;

endmodule

`default_nettype wire

// ===== src/rotation_matrix_to_quaternion.sv =====
// ---------------------------------------------------------------------------
// Rotation matrix to unit quaternion
//
// Input channel mat carries a 3x3 matrix in signed fixed point per transfer;
// output channel quat carries the normalized quaternion (w, x, y, z), the
// branch taken (trace or x term) and a degenerate flag.
// Each matrix yields exactly one result, in order.
// Path from input transfer to output valid: input register, term root,
// first divide, sum of squares, norm root, normalizing divide, output
// register; both square roots and both dividers resolve one bit per stage.
// Throughput: one matrix per cycle while the receiver takes results.
// The pipeline advances as one: when a result waits and quat.ready is low,
// every stage holds and mat.ready drops; nothing is lost or repeated.
// Reset clears all valid bits; payload registers are not reset.
// ---------------------------------------------------------------------------
`default_nettype none

module rotation_matrix_to_quaternion #(
  parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
  input wire logic    clk,
  input wire logic    rst,
  rmq_mat_if.sink     mat,
  rmq_quat_if.source  quat
);

  localparam int IW    = rmq_pkg::IN_W;
  localparam int OW    = rmq_pkg::OUT_W;
  localparam int NQ    = rmq_pkg::QUAT_N;
  localparam int F     = FRAC_BITS;
  localparam int TW    = ((F > IW) ? F : IW) + 2;
  localparam int RW    = ((TW + F + 1) / 2) * 2;
  localparam int RTW   = RW / 2;
  localparam int NW    = IW + 1;
  localparam int CW    = F + 1;
  localparam int HW    = (RTW > CW) ? RTW : CW;
  localparam int DW1   = RTW + 1;
  localparam int NUM1W = NW + F;
  localparam int SQW   = 2 * CW + 2;
  localparam int NRW   = SQW / 2;
  localparam int NUM2W = CW + F;
  localparam int S1W   = 1 + 3 * NW;
  localparam int S2W   = 2 + CW + 3;
  localparam int S3W   = 2 + NQ * CW + NQ;
  localparam int S4W   = 2 + NQ;

  logic en;

  // input register
  logic                 v0;
  logic signed [IW-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;

  assign en        = !quat.valid || quat.ready;
  assign mat.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= mat.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m00 <= mat.m00;
      m01 <= mat.m01;
      m02 <= mat.m02;
      m10 <= mat.m10;
      m11 <= mat.m11;
      m12 <= mat.m12;
      m20 <= mat.m20;
      m21 <= mat.m21;
      m22 <= mat.m22;
    end
  end

  // terms and branch select
  logic signed [TW:0]   one_s, aux1, aux2, tsel;
  logic [TW-1:0]        tval;
  logic                 xb0;
  logic signed [NW-1:0] n0, n1, n2;
  logic [RW-1:0]        rad1;
  logic [S1W-1:0]       side1;

  always_comb begin
    one_s = (TW+1)'(1) << F;
    aux1  = one_s + (TW+1)'(m00) + (TW+1)'(m11) + (TW+1)'(m22);
    aux2  = one_s + (TW+1)'(m00) - (TW+1)'(m11) - (TW+1)'(m22);
    xb0   = !(aux1 > aux2);
    tsel  = xb0 ? aux2 : aux1;
    tval  = tsel[TW] ? '0 : tsel[TW-1:0];
    rad1  = RW'(tval) << F;
    if (xb0) begin
      n0 = NW'(m01) + NW'(m10);
      n1 = NW'(m02) + NW'(m20);
      n2 = NW'(m21) - NW'(m12);
    end else begin
      n0 = NW'(m21) - NW'(m12);
      n1 = NW'(m02) - NW'(m20);
      n2 = NW'(m10) - NW'(m01);
    end
    side1 = {xb0, n0, n1, n2};
  end

  logic           v1;
  logic [RTW-1:0] root1;
  logic [S1W-1:0] side1_o;

  rmq_sqrt #(.RIW(RW), .SW(S1W)) u_term_sqrt (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v0), .radicand(rad1), .side_in(side1),
    .out_valid(v1), .root(root1), .side_out(side1_o)
  );

  // half root, divisor, numerator magnitudes
  logic signed [NW-1:0] nn [3];
  logic [NW-1:0]        nmag [3];
  logic [NUM1W-1:0]     num1 [3];
  logic [HW-1:0]        hval;
  logic [CW-1:0]        hc;
  logic                 hdeg;
  logic [DW1-1:0]       den1;
  logic [S2W-1:0]       side2;

  always_comb begin
    nn[0] = $signed(side1_o[3*NW-1:2*NW]);
    nn[1] = $signed(side1_o[2*NW-1:NW]);
    nn[2] = $signed(side1_o[NW-1:0]);
    for (int l = 0; l < 3; l++) begin
      nmag[l] = nn[l][NW-1] ? NW'(-nn[l]) : NW'(nn[l]);
      num1[l] = NUM1W'(nmag[l]) << F;
    end
    hval  = HW'(root1 >> 1);
    hdeg  = (hval == '0);
    hc    = (hval > HW'({CW{1'b1}})) ? {CW{1'b1}} : CW'(hval);
    den1  = {root1, 1'b0};
    side2 = {side1_o[S1W-1], hdeg, hc, nn[0][NW-1], nn[1][NW-1], nn[2][NW-1]};
  end

  logic           v2;
  logic [CW-1:0]  q1 [3];
  logic           ovf1 [3];
  logic [S2W-1:0] side2_o;

  rmq_div #(.NW(NUM1W), .DW(DW1), .QW(CW), .NL(3), .SW(S2W)) u_term_div (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v1), .num(num1), .den(den1), .side_in(side2),
    .out_valid(v2), .quo(q1), .ovf(ovf1), .side_out(side2_o)
  );

  // place components as w, x, y, z
  logic [CW-1:0]  qs [3];
  logic [CW-1:0]  cm [NQ];
  logic           cs [NQ];
  logic           xb2;
  logic [S3W-1:0] side3;

  always_comb begin
    xb2 = side2_o[S2W-1];
    for (int l = 0; l < 3; l++) begin
      qs[l] = ovf1[l] ? {CW{1'b1}} : q1[l];
    end
    if (xb2) begin
      cm[0] = qs[2];            cs[0] = side2_o[0];
      cm[1] = side2_o[CW+2:3];  cs[1] = 1'b0;
      cm[2] = qs[0];            cs[2] = side2_o[2];
      cm[3] = qs[1];            cs[3] = side2_o[1];
    end else begin
      cm[0] = side2_o[CW+2:3];  cs[0] = 1'b0;
      cm[1] = qs[0];            cs[1] = side2_o[2];
      cm[2] = qs[1];            cs[2] = side2_o[1];
      cm[3] = qs[2];            cs[3] = side2_o[0];
    end
    side3 = {xb2, side2_o[S2W-2], cm[0], cm[1], cm[2], cm[3], cs[0], cs[1], cs[2], cs[3]};
  end

  logic           v3;
  logic [SQW-1:0] ssum;
  logic [S3W-1:0] side3_o;

  rmq_sumsq #(.MW(CW), .SW(S3W)) u_sumsq (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v2), .mag(cm), .side_in(side3),
    .out_valid(v3), .sum(ssum), .side_out(side3_o)
  );

  logic           v4;
  logic [NRW-1:0] norm;
  logic [S3W-1:0] side4_o;

  rmq_sqrt #(.RIW(SQW), .SW(S3W)) u_norm_sqrt (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v3), .radicand(ssum), .side_in(side3_o),
    .out_valid(v4), .root(norm), .side_out(side4_o)
  );

  // normalize
  logic [NUM2W-1:0] num2 [NQ];
  logic             degen4;
  logic [S4W-1:0]   side4;

  always_comb begin
    for (int k = 0; k < NQ; k++) begin
      num2[k] = NUM2W'(side4_o[NQ + (NQ-1-k)*CW +: CW]) << F;
    end
    degen4 = side4_o[S3W-2] || (norm == '0);
    side4  = {side4_o[S3W-1], degen4, side4_o[NQ-1:0]};
  end

  logic           v5;
  logic [OW-1:0]  q2 [NQ];
  logic           ovf2 [NQ];
  logic [S4W-1:0] side5_o;

  rmq_div #(.NW(NUM2W), .DW(NRW), .QW(OW), .NL(NQ), .SW(S4W)) u_norm_div (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v4), .num(num2), .den(norm), .side_in(side4),
    .out_valid(v5), .quo(q2), .ovf(ovf2), .side_out(side5_o)
  );

  // saturate, restore sign, apply degenerate result
  logic [OW-1:0]        qa [NQ];
  logic signed [OW-1:0] res [NQ];
  logic                 xb5, degen5;

  always_comb begin
    xb5    = side5_o[S4W-1];
    degen5 = side5_o[S4W-2];
    for (int k = 0; k < NQ; k++) begin
      qa[k] = ovf2[k] ? {OW{1'b1}} : q2[k];
      if (side5_o[NQ-1-k]) begin
        res[k] = (qa[k] > $unsigned(rmq_pkg::OUT_MIN)) ? rmq_pkg::OUT_MIN
                                                       : $signed(OW'(0) - qa[k]);
      end else begin
        res[k] = (qa[k] > $unsigned(rmq_pkg::OUT_MAX)) ? rmq_pkg::OUT_MAX : $signed(qa[k]);
      end
    end
    if (degen5) begin
      for (int k = 0; k < NQ; k++) begin
        res[k] = '0;
      end
      if (xb5) begin
        res[1] = rmq_pkg::OUT_MAX;
      end else begin
        res[0] = rmq_pkg::OUT_MAX;
      end
    end
  end

  // output register
  logic                 out_valid;
  logic signed [OW-1:0] out_w, out_x, out_y, out_z;
  logic                 out_xb, out_degen;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_w     <= res[0];
      out_x     <= res[1];
      out_y     <= res[2];
      out_z     <= res[3];
      out_xb    <= xb5;
      out_degen <= degen5;
    end
  end

  assign quat.valid      = out_valid;
  assign quat.quat_w     = out_w;
  assign quat.quat_x     = out_x;
  assign quat.quat_y     = out_y;
  assign quat.quat_z     = out_z;
  assign quat.x_branch   = out_xb;
  assign quat.degenerate = out_degen;

endmodule

`default_nettype wire

// ===== src/rmq_checker.sv =====
// ---------------------------------------------------------------------------
// Rotation matrix to quaternion: port checker
// Watches the top level ports for flow control and result shape.
// ---------------------------------------------------------------------------
`default_nettype none

`include "rotation_matrix_to_quaternion_defines.svh"

module rmq_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              mat_ready,
  input wire logic                              quat_valid,
  input wire logic                              quat_ready,
  input wire logic signed [rmq_pkg::OUT_W-1:0] quat_w,
  input wire logic signed [rmq_pkg::OUT_W-1:0] quat_x,
  input wire logic signed [rmq_pkg::OUT_W-1:0] quat_y,
  input wire logic signed [rmq_pkg::OUT_W-1:0] quat_z,
  input wire logic                              x_branch,
  input wire logic                              degenerate
);

  `RMQ_ASSERT(in_ready_when_free, (!quat_valid || quat_ready), mat_ready)

  `RMQ_ASSERT_NEXT(out_hold_on_stall, (quat_valid && !quat_ready), (quat_valid && $stable(quat_w) && $stable(quat_x) && $stable(quat_y) && $stable(quat_z)))

  `RMQ_ASSERT(degenerate_shape, (quat_valid && degenerate), ((x_branch && quat_x == rmq_pkg::OUT_MAX && quat_w == 0 && quat_y == 0 && quat_z == 0) || (!x_branch && quat_w == rmq_pkg::OUT_MAX && quat_x == 0 && quat_y == 0 && quat_z == 0)))

  `RMQ_ASSERT_ALWAYS(no_valid_after_reset, $past(rst), !quat_valid)

endmodule

bind rotation_matrix_to_quaternion rmq_checker u_rmq_checker (
  .clk(clk),
  .rst(rst),
  .mat_ready(mat.ready),
  .quat_valid(quat.valid),
  .quat_ready(quat.ready),
  .quat_w(quat.quat_w),
  .quat_x(quat.quat_x),
  .quat_y(quat.quat_y),
  .quat_z(quat.quat_z),
  .x_branch(quat.x_branch),
  .degenerate(quat.degenerate)
);

`default_nettype wire
